[rtl/ppsb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ppsb_pkg;

    // Bridge phases; code 7 is unused and behaves as idle
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_TX   = 3'd1,
        PH_REL  = 3'd2,
        PH_RDY  = 3'd3,
        PH_DRV  = 3'd4,
        PH_TURN = 3'd5,
        PH_END  = 3'd6
    } phase_t;

    // Data lines value when the port is released
    localparam logic [7:0] PORT_RELEASED = 8'hFF;

    // Ring buffer status seen by the control logic
    typedef struct packed {
        logic empty;
        logic full;
    } ring_stat_t;

    // One result transaction
    typedef struct packed {
        logic       busy_res;
        logic       data_ready_n;
        logic [7:0] port_data;
        logic       port_drive;
        logic       tx_start;
        logic [7:0] tx_byte;
        logic       tx_bit9;
        logic       bus_drive_enable;
        logic       rx_dropped;
    } result_t;

endpackage

`default_nettype wire

[rtl/parallel_port_serial_bridge_top.sv]
// A result is registered and appears in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle unless stalled, set by the single state update stage;
// the ring buffer read port is registered and used only from the next transaction.
// Reset: asynchronous, active low; bridge idle, buffer empty, busy low, no result
// pending. Buffer contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module parallel_port_serial_bridge_top #(
    parameter int BUF_DEPTH = 1024
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       strobe_n,
    input  wire logic       ack_n,
    input  wire logic [7:0] host_data,
    input  wire logic       host_bit9,
    input  wire logic       rx_valid,
    input  wire logic [7:0] rx_byte,
    input  wire logic       tx_done,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            busy_res,
    output logic            data_ready_n,
    output logic [7:0]      port_data,
    output logic            port_drive,
    output logic            tx_start,
    output logic [7:0]      tx_byte,
    output logic            tx_bit9,
    output logic            bus_drive_enable,
    output logic            rx_dropped
);

    logic                 step;
    logic                 pop_req;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [7:0]           rd_data;
    ppsb_pkg::ring_stat_t stat;
    ppsb_pkg::result_t    res;

    // Accept while the result register is empty or being taken
    assign in_stall = out_valid_reg & out_stall;
    assign step     = in_valid & ~in_stall;

    ppsb_ring #(
        .BUF_DEPTH(BUF_DEPTH)
    ) u_ring (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_req (step & rx_valid),
        .push_data(rx_byte),
        .pop_req  (pop_req),
        .stat     (stat),
        .rd_data  (rd_data)
    );

    ppsb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .strobe_n (strobe_n),
        .ack_n    (ack_n),
        .host_data(host_data),
        .host_bit9(host_bit9),
        .rx_valid (rx_valid),
        .tx_done  (tx_done),
        .stat     (stat),
        .rd_data  (rd_data),
        .pop_req  (pop_req),
        .res      (res)
    );

    // Track the pending result transaction
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign out_valid        = out_valid_reg;
    assign busy_res         = res.busy_res;
    assign data_ready_n     = res.data_ready_n;
    assign port_data        = res.port_data;
    assign port_drive       = res.port_drive;
    assign tx_start         = res.tx_start;
    assign tx_byte          = res.tx_byte;
    assign tx_bit9          = res.tx_bit9;
    assign bus_drive_enable = res.bus_drive_enable;
    assign rx_dropped       = res.rx_dropped;

    // A transmit start always comes with busy and the bus driver on
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tx_start |-> busy_res && bus_drive_enable)
        else $error("tx_start without busy or bus drive");

    // The host port is never driven while a host byte is in hand
    a_drive_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && port_drive |-> !busy_res && data_ready_n && !bus_drive_enable)
        else $error("port driven while busy");

    // The ring is never both empty and full
    a_ring_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(stat.empty && stat.full))
        else $error("ring empty and full at once");

    // A pop only happens on an accepted transaction with data present
    a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
        pop_req |-> step && !stat.empty)
        else $error("pop from empty ring");

endmodule

`default_nettype wire

[rtl/ppsb_ring.sv]
`timescale 1ns / 1ps
`default_nettype none

module ppsb_ring #(
    parameter int BUF_DEPTH = 1024
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push_req,
    input  wire logic [7:0]            push_data,
    input  wire logic                  pop_req,
    output ppsb_pkg::ring_stat_t       stat,
    output logic [7:0]                 rd_data
);

    localparam int IdxW = $clog2(BUF_DEPTH);
    localparam logic [IdxW-1:0] LastIdx = IdxW'(BUF_DEPTH - 1);

    logic [7:0]      mem [BUF_DEPTH];
    logic [IdxW-1:0] head_reg;
    logic [IdxW-1:0] head_next;
    logic [IdxW-1:0] tail_reg;
    logic [IdxW-1:0] tail_next;
    logic [IdxW-1:0] head_inc;
    logic [IdxW-1:0] tail_inc;
    logic [7:0]      rd_data_reg;
    logic            push_en;

    // Wrap the indices at the buffer depth
    always_comb
    begin
        head_inc = (head_reg == LastIdx) ? '0 : head_reg + 1'b1;
        tail_inc = (tail_reg == LastIdx) ? '0 : tail_reg + 1'b1;
    end

    // Judge full and empty on the indices at the start of the cycle
    assign stat.empty = (head_reg == tail_reg);
    assign stat.full  = (head_inc == tail_reg);
    assign push_en    = push_req & ~stat.full;

    always_comb
    begin
        head_next = push_en ? head_inc : head_reg;
        tail_next = pop_req ? tail_inc : tail_reg;
    end

    // Advance the indices
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    // Write the received byte at the head
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            mem[head_reg] <= push_data;
        end
    end

    // Read the oldest byte at the tail on a pop
    always_ff @(posedge clk)
    begin
        if (pop_req)
        begin
            rd_data_reg <= mem[tail_reg];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/ppsb_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module ppsb_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire logic                 strobe_n,
    input  wire logic                 ack_n,
    input  wire logic [7:0]           host_data,
    input  wire logic                 host_bit9,
    input  wire logic                 rx_valid,
    input  wire logic                 tx_done,
    input  wire ppsb_pkg::ring_stat_t stat,
    input  wire logic [7:0]           rd_data,
    output logic                      pop_req,
    output ppsb_pkg::result_t         res
);

    ppsb_pkg::phase_t  phase_reg;
    ppsb_pkg::phase_t  phase_next;
    logic              busy_reg;
    logic              busy_next;
    logic [7:0]        held_byte_reg;
    logic              held_bit9_reg;
    logic              held_sel_reg;
    logic              latch;
    logic              pop;
    logic [7:0]        held_eff;
    logic [7:0]        show_byte;
    logic              show_bit9;
    ppsb_pkg::result_t res_reg;
    ppsb_pkg::result_t res_next;

    // A popped byte lives in the ring read register until the next latch or pop
    assign held_eff = held_sel_reg ? rd_data : held_byte_reg;

    // Next phase and busy for this transaction
    always_comb
    begin
        phase_next = phase_reg;
        busy_next  = busy_reg;
        latch      = 1'b0;
        pop        = 1'b0;
        case (phase_reg)
            ppsb_pkg::PH_TX:
            begin
                if (tx_done)
                begin
                    if (strobe_n)
                    begin
                        busy_next  = 1'b0;
                        phase_next = ppsb_pkg::PH_IDLE;
                    end
                    else
                    begin
                        phase_next = ppsb_pkg::PH_REL;
                    end
                end
            end
            ppsb_pkg::PH_REL:
            begin
                if (strobe_n)
                begin
                    busy_next  = 1'b0;
                    phase_next = ppsb_pkg::PH_IDLE;
                end
            end
            ppsb_pkg::PH_RDY:
            begin
                if (!ack_n)
                    phase_next = ppsb_pkg::PH_DRV;
            end
            ppsb_pkg::PH_DRV:
            begin
                if (ack_n)
                    phase_next = ppsb_pkg::PH_TURN;
            end
            ppsb_pkg::PH_TURN:
            begin
                if (!ack_n)
                    phase_next = ppsb_pkg::PH_END;
            end
            ppsb_pkg::PH_END:
            begin
                if (ack_n)
                    phase_next = ppsb_pkg::PH_IDLE;
            end
            default:
            begin
                // Strobe wins over a pending hand-over
                if (!strobe_n)
                begin
                    latch      = 1'b1;
                    busy_next  = 1'b1;
                    phase_next = ppsb_pkg::PH_TX;
                end
                else if (!stat.empty)
                begin
                    pop        = 1'b1;
                    phase_next = ppsb_pkg::PH_RDY;
                end
            end
        endcase
    end

    assign pop_req = step & pop;

    // Build the result from the updated state
    always_comb
    begin
        show_byte = latch ? host_data : held_eff;
        show_bit9 = latch ? host_bit9 : held_bit9_reg;

        res_next.busy_res     = busy_next;
        res_next.data_ready_n = !((phase_next == ppsb_pkg::PH_RDY)
                                  || (phase_next == ppsb_pkg::PH_TURN));
        res_next.port_drive   = (phase_next == ppsb_pkg::PH_DRV);
        res_next.port_data    = res_next.port_drive ? show_byte
                                                    : ppsb_pkg::PORT_RELEASED;
        res_next.tx_start     = latch;
        res_next.bus_drive_enable = (phase_next == ppsb_pkg::PH_TX);
        res_next.tx_byte      = res_next.bus_drive_enable ? show_byte : 8'h00;
        res_next.tx_bit9      = res_next.bus_drive_enable & show_bit9;
        res_next.rx_dropped   = rx_valid & stat.full;
    end

    // Hold control state between transactions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= ppsb_pkg::PH_IDLE;
            busy_reg      <= 1'b0;
            held_byte_reg <= 8'h00;
            held_bit9_reg <= 1'b0;
            held_sel_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            busy_reg  <= busy_next;
            if (latch)
            begin
                held_byte_reg <= host_data;
                held_bit9_reg <= host_bit9;
                held_sel_reg  <= 1'b0;
            end
            else if (pop)
            begin
                held_sel_reg <= 1'b1;
            end
        end
    end

    // Register the result
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire
